// File: src/rvde_pkg.sv
`timescale 1ns / 1ps

package rvde_pkg;

  // Major opcodes, instruction bits 6:0
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6f;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcOp     = 7'h33;

  // ALU funct3
  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Sr   = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  // Branch funct3
  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  // Load / store funct3
  localparam logic [2:0] F3Byte  = 3'd0;
  localparam logic [2:0] F3Half  = 3'd1;
  localparam logic [2:0] F3Word  = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4;
  localparam logic [2:0] F3HalfU = 3'd5;

  // addi x10,x0,255 marks end of program
  localparam logic [31:0] HaltWord = 32'h0ff0_0513;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LUI    = 4'd1,
    OP_AUIPC  = 4'd2,
    OP_JAL    = 4'd3,
    OP_JALR   = 4'd4,
    OP_BRANCH = 4'd5,
    OP_LOAD   = 4'd6,
    OP_STORE  = 4'd7,
    OP_IMM    = 4'd8,
    OP_REG    = 4'd9
  } op_e;

  // decode -> execute
  typedef struct packed {
    op_e         op;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] rs1;
    logic [31:0] rs2;
    logic [31:0] ld;
    logic        halt;
  } dec_t;

  // execute -> format
  typedef struct packed {
    op_e         op;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] alu;
    logic [31:0] sum;
    logic [31:0] pc4;
    logic        taken;
    logic [31:0] rs2;
    logic [31:0] ld;
    logic        halt;
  } exe_t;

endpackage

// File: src/rv32i_decode_execute.sv
`timescale 1ns / 1ps

// RV32I integer decode/execute unit, three register stages: decode (field
// split, immediate build, operand select), execute (ALU, address/target
// adder, branch compare) and format (write-back value, load extension,
// next pc, memory request), the last being the output register. One
// instruction transfers in per clock while in_ready_o is high. All stages
// move together on a single enable that is high when the output register
// is empty or its result is being taken, so a stall freezes the whole pipe
// and bubbles travel as cleared valid bits.
module rv32i_decode_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  // instruction channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] rs1_value_i,
  input  logic [31:0] rs2_value_i,
  input  logic [31:0] load_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        rd_write_o,
  output logic [4:0]  rd_index_o,
  output logic [31:0] rd_value_o,
  output logic [31:0] next_pc_o,
  output logic        redirect_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic [31:0] mem_addr_o,
  output logic [1:0]  mem_size_o,
  output logic [31:0] store_data_o,
  output logic        halt_o
);

  logic adv;
  logic dec_vld_q, exe_vld_q, out_vld_q;

  rvde_pkg::dec_t dec_d, dec_q;
  rvde_pkg::exe_t exe_d, exe_q;

  // global advance: output slot free or its transfer completes now
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
      exe_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      dec_vld_q <= in_valid_i;
      exe_vld_q <= dec_vld_q;
      out_vld_q <= exe_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: decode
  // ---------------------------------------------------------------------
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

  assign opc   = instr_i[6:0];
  assign f3    = instr_i[14:12];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};

  always_comb begin
    dec_d      = '0;
    dec_d.op   = rvde_pkg::OP_NONE;
    dec_d.f3   = f3;
    dec_d.rd   = instr_i[11:7];
    dec_d.pc   = pc_i;
    dec_d.rs1  = rs1_value_i;
    dec_d.rs2  = rs2_value_i;
    dec_d.ld   = load_data_i;
    dec_d.halt = (instr_i == rvde_pkg::HaltWord);
    case (opc)
      rvde_pkg::OpcLui: begin
        dec_d.op  = rvde_pkg::OP_LUI;
        dec_d.imm = imm_u;
      end
      rvde_pkg::OpcAuipc: begin
        dec_d.op  = rvde_pkg::OP_AUIPC;
        dec_d.imm = imm_u;
      end
      rvde_pkg::OpcJal: begin
        dec_d.op  = rvde_pkg::OP_JAL;
        dec_d.imm = imm_j;
      end
      rvde_pkg::OpcJalr: begin
        dec_d.op  = rvde_pkg::OP_JALR;
        dec_d.imm = imm_i;
      end
      rvde_pkg::OpcBranch: begin
        dec_d.op  = rvde_pkg::OP_BRANCH;
        dec_d.imm = imm_b;
      end
      rvde_pkg::OpcLoad: begin
        // undefined widths fall through as a no-op
        if (f3 == rvde_pkg::F3Byte || f3 == rvde_pkg::F3Half ||
            f3 == rvde_pkg::F3Word || f3 == rvde_pkg::F3ByteU ||
            f3 == rvde_pkg::F3HalfU) begin
          dec_d.op = rvde_pkg::OP_LOAD;
        end
        dec_d.imm = imm_i;
      end
      rvde_pkg::OpcStore: begin
        if (f3 == rvde_pkg::F3Byte || f3 == rvde_pkg::F3Half ||
            f3 == rvde_pkg::F3Word) begin
          dec_d.op = rvde_pkg::OP_STORE;
        end
        dec_d.imm = imm_s;
      end
      rvde_pkg::OpcOpImm: begin
        dec_d.op = rvde_pkg::OP_IMM;
        if (f3 == rvde_pkg::F3Sll || f3 == rvde_pkg::F3Sr) begin
          dec_d.imm = {27'b0, instr_i[24:20]};
          dec_d.alt = instr_i[30] && (f3 == rvde_pkg::F3Sr);
        end else begin
          dec_d.imm = imm_i;
        end
      end
      rvde_pkg::OpcOp: begin
        dec_d.op  = rvde_pkg::OP_REG;
        dec_d.alt = instr_i[30] && (f3 == rvde_pkg::F3Add || f3 == rvde_pkg::F3Sr);
      end
      default: begin
        dec_d.op = rvde_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_q <= dec_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: execute
  // ---------------------------------------------------------------------
  logic [31:0] opb, base;
  logic [4:0]  shamt;
  logic        lt_s, lt_u;

  assign opb   = (dec_q.op == rvde_pkg::OP_REG) ? dec_q.rs2 : dec_q.imm;
  assign shamt = opb[4:0];
  assign lt_s  = $signed(dec_q.rs1) < $signed(opb);
  assign lt_u  = dec_q.rs1 < opb;
  // pc-relative for AUIPC, JAL and branches; rs1-relative otherwise
  assign base  = (dec_q.op == rvde_pkg::OP_AUIPC || dec_q.op == rvde_pkg::OP_JAL ||
                  dec_q.op == rvde_pkg::OP_BRANCH) ? dec_q.pc : dec_q.rs1;

  logic        br_eq, br_lt_s, br_lt_u;
  assign br_eq   = dec_q.rs1 == dec_q.rs2;
  assign br_lt_s = $signed(dec_q.rs1) < $signed(dec_q.rs2);
  assign br_lt_u = dec_q.rs1 < dec_q.rs2;

  always_comb begin
    exe_d      = '0;
    exe_d.op   = dec_q.op;
    exe_d.f3   = dec_q.f3;
    exe_d.rd   = dec_q.rd;
    exe_d.imm  = dec_q.imm;
    exe_d.sum  = base + dec_q.imm;
    exe_d.pc4  = dec_q.pc + 32'd4;
    exe_d.rs2  = dec_q.rs2;
    exe_d.ld   = dec_q.ld;
    exe_d.halt = dec_q.halt;

    case (dec_q.f3)
      rvde_pkg::F3Add:  exe_d.alu = dec_q.alt ? dec_q.rs1 - opb : dec_q.rs1 + opb;
      rvde_pkg::F3Sll:  exe_d.alu = dec_q.rs1 << shamt;
      rvde_pkg::F3Slt:  exe_d.alu = {31'b0, lt_s};
      rvde_pkg::F3Sltu: exe_d.alu = {31'b0, lt_u};
      rvde_pkg::F3Xor:  exe_d.alu = dec_q.rs1 ^ opb;
      rvde_pkg::F3Sr:   exe_d.alu = dec_q.alt ? 32'($signed(dec_q.rs1) >>> shamt)
                                              : dec_q.rs1 >> shamt;
      rvde_pkg::F3Or:   exe_d.alu = dec_q.rs1 | opb;
      rvde_pkg::F3And:  exe_d.alu = dec_q.rs1 & opb;
      default:          exe_d.alu = dec_q.rs1 & opb;
    endcase

    case (dec_q.f3)
      rvde_pkg::F3Beq:  exe_d.taken = br_eq;
      rvde_pkg::F3Bne:  exe_d.taken = !br_eq;
      rvde_pkg::F3Blt:  exe_d.taken = br_lt_s;
      rvde_pkg::F3Bge:  exe_d.taken = !br_lt_s;
      rvde_pkg::F3Bltu: exe_d.taken = br_lt_u;
      rvde_pkg::F3Bgeu: exe_d.taken = !br_lt_u;
      default:          exe_d.taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      exe_q <= exe_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: format into the output register
  // ---------------------------------------------------------------------
  logic        wr;
  logic [31:0] wb_val, ld_val;

  always_comb begin
    case (exe_q.f3)
      rvde_pkg::F3Byte:  ld_val = {{24{exe_q.ld[7]}}, exe_q.ld[7:0]};
      rvde_pkg::F3Half:  ld_val = {{16{exe_q.ld[15]}}, exe_q.ld[15:0]};
      rvde_pkg::F3ByteU: ld_val = {24'b0, exe_q.ld[7:0]};
      rvde_pkg::F3HalfU: ld_val = {16'b0, exe_q.ld[15:0]};
      default:           ld_val = exe_q.ld;
    endcase
  end

  always_comb begin
    wr     = 1'b1;
    wb_val = '0;
    case (exe_q.op)
      rvde_pkg::OP_LUI:   wb_val = exe_q.imm;
      rvde_pkg::OP_AUIPC: wb_val = exe_q.sum;
      rvde_pkg::OP_JAL:   wb_val = exe_q.pc4;
      rvde_pkg::OP_JALR:  wb_val = exe_q.pc4;
      rvde_pkg::OP_LOAD:  wb_val = ld_val;
      rvde_pkg::OP_IMM:   wb_val = exe_q.alu;
      rvde_pkg::OP_REG:   wb_val = exe_q.alu;
      default:            wr     = 1'b0;
    endcase
    // x0 is never written
    if (exe_q.rd == 5'd0) begin
      wr = 1'b0;
    end
  end

  logic is_mem;
  logic br_redir;
  assign is_mem   = (exe_q.op == rvde_pkg::OP_LOAD) || (exe_q.op == rvde_pkg::OP_STORE);
  assign br_redir = (exe_q.op == rvde_pkg::OP_BRANCH) && exe_q.taken;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_write_o   <= wr;
      rd_index_o   <= wr ? exe_q.rd : 5'd0;
      rd_value_o   <= wr ? wb_val : 32'd0;
      redirect_o   <= (exe_q.op == rvde_pkg::OP_JAL) || (exe_q.op == rvde_pkg::OP_JALR) ||
                      br_redir;
      if (exe_q.op == rvde_pkg::OP_JALR) begin
        next_pc_o <= {exe_q.sum[31:1], 1'b0};
      end else if (exe_q.op == rvde_pkg::OP_JAL || br_redir) begin
        next_pc_o <= exe_q.sum;
      end else begin
        next_pc_o <= exe_q.pc4;
      end
      mem_read_o   <= exe_q.op == rvde_pkg::OP_LOAD;
      mem_write_o  <= exe_q.op == rvde_pkg::OP_STORE;
      mem_addr_o   <= is_mem ? exe_q.sum : 32'd0;
      mem_size_o   <= is_mem ? exe_q.f3[1:0] : 2'd0;
      store_data_o <= (exe_q.op == rvde_pkg::OP_STORE) ? exe_q.rs2 : 32'd0;
      halt_o       <= exe_q.halt;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_wr_nonzero_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rd_write_o |-> rd_index_o != 5'd0)
    else $error("write to x0 issued");

  a_no_wr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rd_write_o |-> rd_index_o == 5'd0 && rd_value_o == 32'd0)
    else $error("idle write port carries data");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(mem_read_o && mem_write_o) && !(redirect_o && (mem_read_o || mem_write_o)))
    else $error("conflicting memory / redirect request");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(exe_vld_q) && $stable(dec_vld_q))
    else $error("pipe moved during stall");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;  // pipe is three deep
  localparam int unsigned NumRandom = 1300;

  // receiver stall behaviors
  localparam int RxAlways  = 0;
  localparam int RxCoin    = 1;
  localparam int RxSparse  = 2;
  localparam int RxPattern = 3;

  localparam logic [6:0] KnownOpcodes [9] = '{
    rvde_pkg::OpcLui, rvde_pkg::OpcAuipc, rvde_pkg::OpcJal, rvde_pkg::OpcJalr,
    rvde_pkg::OpcBranch, rvde_pkg::OpcLoad, rvde_pkg::OpcStore, rvde_pkg::OpcOpImm,
    rvde_pkg::OpcOp
  };

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] pc;
    logic [31:0] rs1;
    logic [31:0] rs2;
    logic [31:0] ld;
    logic        hold;  // wait for the pipe to drain before this transfer
  } instr_item_t;

  typedef struct packed {
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic        redirect;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic        halt;
    logic [31:0] instr;  // for messages only
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] instr_i = '0;
  logic [31:0] pc_i = '0;
  logic [31:0] rs1_value_i = '0;
  logic [31:0] rs2_value_i = '0;
  logic [31:0] load_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        rd_write_o;
  logic [4:0]  rd_index_o;
  logic [31:0] rd_value_o;
  logic [31:0] next_pc_o;
  logic        redirect_o;
  logic        mem_read_o;
  logic        mem_write_o;
  logic [31:0] mem_addr_o;
  logic [1:0]  mem_size_o;
  logic [31:0] store_data_o;
  logic        halt_o;

  instr_item_t  pending_instrs[$];
  exec_result_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  rv32i_decode_execute u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .instr_i      (instr_i),
    .pc_i         (pc_i),
    .rs1_value_i  (rs1_value_i),
    .rs2_value_i  (rs2_value_i),
    .load_data_i  (load_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rd_write_o   (rd_write_o),
    .rd_index_o   (rd_index_o),
    .rd_value_o   (rd_value_o),
    .next_pc_o    (next_pc_o),
    .redirect_o   (redirect_o),
    .mem_read_o   (mem_read_o),
    .mem_write_o  (mem_write_o),
    .mem_addr_o   (mem_addr_o),
    .mem_size_o   (mem_size_o),
    .store_data_o (store_data_o),
    .halt_o       (halt_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Golden execute model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt,
                                           logic [31:0] a, logic [31:0] b);
    logic [31:0] res;
    case (f3)
      rvde_pkg::F3Add:  res = alt ? a - b : a + b;
      rvde_pkg::F3Sll:  res = a << b[4:0];
      rvde_pkg::F3Slt:  res = {31'b0, $signed(a) < $signed(b)};
      rvde_pkg::F3Sltu: res = {31'b0, a < b};
      rvde_pkg::F3Xor:  res = a ^ b;
      rvde_pkg::F3Sr: begin
        // keep the arithmetic shift out of a mixed-sign ternary
        if (alt) res = $signed(a) >>> b[4:0];
        else     res = a >> b[4:0];
      end
      rvde_pkg::F3Or:   res = a | b;
      default: res = a & b;
    endcase
    return res;
  endfunction

  function automatic exec_result_t predict_exec(logic [31:0] ins, logic [31:0] pc,
                                                logic [31:0] a, logic [31:0] b,
                                                logic [31:0] ld);
    exec_result_t r;
    logic [31:0]  imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [2:0]   f3;
    logic         taken;
    f3    = ins[14:12];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_u = {ins[31:12], 12'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    r = '0;
    r.instr   = ins;
    r.next_pc = pc + 32'd4;
    r.halt    = (ins == rvde_pkg::HaltWord);
    case (ins[6:0])
      rvde_pkg::OpcLui: begin
        r.rd_write = 1'b1;
        r.rd_value = imm_u;
      end
      rvde_pkg::OpcAuipc: begin
        r.rd_write = 1'b1;
        r.rd_value = pc + imm_u;
      end
      rvde_pkg::OpcJal: begin
        r.rd_write = 1'b1;
        r.rd_value = pc + 32'd4;
        r.next_pc  = pc + imm_j;
        r.redirect = 1'b1;
      end
      rvde_pkg::OpcJalr: begin
        r.rd_write = 1'b1;
        r.rd_value = pc + 32'd4;
        r.next_pc  = (a + imm_i) & ~32'd1;
        r.redirect = 1'b1;
      end
      rvde_pkg::OpcBranch: begin
        case (f3)
          rvde_pkg::F3Beq:  taken = (a == b);
          rvde_pkg::F3Bne:  taken = (a != b);
          rvde_pkg::F3Blt:  taken = $signed(a) < $signed(b);
          rvde_pkg::F3Bge:  taken = $signed(a) >= $signed(b);
          rvde_pkg::F3Bltu: taken = a < b;
          rvde_pkg::F3Bgeu: taken = a >= b;
          default:          taken = 1'b0;
        endcase
        if (taken) begin
          r.next_pc  = pc + imm_b;
          r.redirect = 1'b1;
        end
      end
      rvde_pkg::OpcLoad: begin
        if (f3 == rvde_pkg::F3Byte || f3 == rvde_pkg::F3Half || f3 == rvde_pkg::F3Word ||
            f3 == rvde_pkg::F3ByteU || f3 == rvde_pkg::F3HalfU) begin
          r.mem_read = 1'b1;
          r.rd_write = 1'b1;
          r.mem_addr = a + imm_i;
          r.mem_size = f3[1:0];
          case (f3)
            rvde_pkg::F3Byte:  r.rd_value = {{24{ld[7]}}, ld[7:0]};
            rvde_pkg::F3Half:  r.rd_value = {{16{ld[15]}}, ld[15:0]};
            rvde_pkg::F3ByteU: r.rd_value = {24'b0, ld[7:0]};
            rvde_pkg::F3HalfU: r.rd_value = {16'b0, ld[15:0]};
            default:           r.rd_value = ld;
          endcase
        end
      end
      rvde_pkg::OpcStore: begin
        if (f3 <= rvde_pkg::F3Word) begin
          r.mem_write  = 1'b1;
          r.mem_addr   = a + imm_s;
          r.mem_size   = f3[1:0];
          r.store_data = b;
        end
      end
      rvde_pkg::OpcOpImm: begin
        r.rd_write = 1'b1;
        // shift-immediates: amount in bits 24:20, only bit 30 selects SRAI
        if (f3 == rvde_pkg::F3Sll || f3 == rvde_pkg::F3Sr)
          r.rd_value = alu_calc(f3, ins[30] && f3 == rvde_pkg::F3Sr, a,
                                {27'b0, ins[24:20]});
        else
          r.rd_value = alu_calc(f3, 1'b0, a, imm_i);
      end
      rvde_pkg::OpcOp: begin
        r.rd_write = 1'b1;
        r.rd_value = alu_calc(f3, ins[30] && (f3 == rvde_pkg::F3Add ||
                                              f3 == rvde_pkg::F3Sr), a, b);
      end
      default: ;  // unknown opcode is a no-op
    endcase
    if (ins[11:7] == 5'd0) r.rd_write = 1'b0;
    if (r.rd_write) r.rd_index = ins[11:7];
    else r.rd_value = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] encode(logic [6:0] f7, logic [4:0] r2, logic [4:0] r1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, r2, r1, f3, rd, opc};
  endfunction

  // operand values lean toward the corners of signed/unsigned compares
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h0000_0000;
      1: w = 32'hffff_ffff;
      2: w = 32'h8000_0000;
      3: w = 32'h7fff_ffff;
      4: w = $urandom_range(0, 40);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic queue_instr(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                             logic [31:0] b, logic [31:0] ld, logic hold);
    instr_item_t it;
    it.instr = ins;
    it.pc    = pc;
    it.rs1   = a;
    it.rs2   = b;
    it.ld    = ld;
    it.hold  = hold;
    pending_instrs.push_back(it);
  endtask

  // mostly decodable words with random fields, some raw noise
  function automatic logic [31:0] rand_instr();
    logic [31:0] ins;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    ins  = $urandom;
    if (pick < 3) begin
      ins = rvde_pkg::HaltWord;
    end else if (pick >= 15) begin
      ins[6:0] = KnownOpcodes[4'($urandom_range(0, 8))];
      if ($urandom_range(0, 9) == 0) ins[11:7] = 5'd0;
      // OP and shift-immediates: mostly the canonical funct7 values
      if ((ins[6:0] == rvde_pkg::OpcOp || (ins[6:0] == rvde_pkg::OpcOpImm &&
          (ins[14:12] == rvde_pkg::F3Sll || ins[14:12] == rvde_pkg::F3Sr))) &&
          $urandom_range(0, 3) != 0)
        ins[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
    end
    return ins;
  endfunction

  // ---------------------------------------------------------------------------
  // Instruction driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------

  instr_item_t drv_item;
  int unsigned burst_left;
  int unsigned gap_left;
  logic        drv_valid;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      instr_i     <= '0;
      pc_i        <= '0;
      rs1_value_i <= '0;
      rs2_value_i <= '0;
      load_data_i <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else begin
      // transfer this edge: the ports still hold the accepted item
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_exec(instr_i, pc_i, rs1_value_i,
                                                rs2_value_i, load_data_i));
      if (!(in_valid_i && !in_ready_o)) begin
        drv_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_instrs.size() > 0 &&
                     !(pending_instrs[0].hold && expected_results.size() != 0)) begin
          drv_item    = pending_instrs.pop_front();
          drv_valid   = 1'b1;
          instr_i     <= drv_item.instr;
          pc_i        <= drv_item.pc;
          rs1_value_i <= drv_item.rs1;
          rs2_value_i <= drv_item.rs2;
          load_data_i <= drv_item.ld;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        in_valid_i <= drv_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall behavior changes to a random mode after each phase of random length
  // ---------------------------------------------------------------------------

  int          rx_mode;
  int unsigned rx_phase_left;
  logic [7:0]  rx_pattern;
  logic        rx_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      rx_mode       = RxAlways;
      rx_phase_left = 0;
      rx_pattern    = 8'hff;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = int'($urandom_range(RxAlways, RxPattern));
        rx_phase_left = $urandom_range(50, 300);
        rx_pattern    = 8'($urandom);
        if (rx_pattern == 8'h00) rx_pattern = 8'h01;
      end
      rx_phase_left--;
      case (rx_mode)
        RxCoin:    rx_ready = 1'($urandom_range(0, 1));
        RxSparse:  rx_ready = ($urandom_range(0, 3) == 0);
        RxPattern: begin
          rx_ready   = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
        default:   rx_ready = 1'b1;
      endcase
      out_ready_i <= rx_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                             logic [31:0] ins);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: got %h want %h (instr %h)", name, got, want, ins);
    end
  endtask

  exec_result_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing outstanding");
      end else begin
        mon_want = expected_results.pop_front();
        check_field("rd_write",   32'(rd_write_o),   32'(mon_want.rd_write),
                    mon_want.instr);
        check_field("rd_index",   32'(rd_index_o),   32'(mon_want.rd_index),
                    mon_want.instr);
        check_field("rd_value",   rd_value_o,        mon_want.rd_value,
                    mon_want.instr);
        check_field("next_pc",    next_pc_o,         mon_want.next_pc,
                    mon_want.instr);
        check_field("redirect",   32'(redirect_o),   32'(mon_want.redirect),
                    mon_want.instr);
        check_field("mem_read",   32'(mem_read_o),   32'(mon_want.mem_read),
                    mon_want.instr);
        check_field("mem_write",  32'(mem_write_o),  32'(mon_want.mem_write),
                    mon_want.instr);
        check_field("mem_addr",   mem_addr_o,        mon_want.mem_addr,
                    mon_want.instr);
        check_field("mem_size",   32'(mem_size_o),   32'(mon_want.mem_size),
                    mon_want.instr);
        check_field("store_data", store_data_o,      mon_want.store_data,
                    mon_want.instr);
        check_field("halt",       32'(halt_o),       32'(mon_want.halt),
                    mon_want.instr);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  logic [2:0] ld_f3s [6] = '{rvde_pkg::F3Byte, rvde_pkg::F3Half, rvde_pkg::F3Word,
                             rvde_pkg::F3ByteU, rvde_pkg::F3HalfU, 3'd6};

  initial begin
    // LUI with all-ones immediate, AUIPC wrapping past the top of memory
    queue_instr(encode(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd5, rvde_pkg::OpcLui), 32'h0,
                rand_word(), rand_word(), rand_word(), 1'b0);
    queue_instr(encode(7'h00, 5'h00, 5'h00, 3'h1, 5'd31, rvde_pkg::OpcAuipc), 32'hffff_f004,
                rand_word(), rand_word(), rand_word(), 1'b0);
    // JAL with an all-ones offset field (offset -2), JALR with stray funct3 and odd target
    queue_instr(encode(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd1, rvde_pkg::OpcJal), 32'h0000_0010,
                rand_word(), rand_word(), rand_word(), 1'b0);
    queue_instr(encode(7'h00, 5'd3, 5'd2, 3'd3, 5'd1, rvde_pkg::OpcJalr), 32'h0000_0040,
                32'h0000_1000, rand_word(), rand_word(), 1'b0);
    // every branch funct3, defined or not; signed and unsigned order disagree
    for (int i = 0; i < 8; i++)
      queue_instr(encode(7'h40, 5'd2, 5'd1, i[2:0], 5'h10, rvde_pkg::OpcBranch), 32'h100,
                  32'h8000_0000, 32'h1, rand_word(), 1'b0);
    // loads: sign extension, rd = funct3 so the byte load goes to x0,
    // one undefined funct3; offset -1 from zero wraps the address
    foreach (ld_f3s[i])
      queue_instr(encode(7'h7f, 5'h1f, 5'd4, ld_f3s[i], {2'b0, ld_f3s[i]},
                         rvde_pkg::OpcLoad),
                  32'h200, 32'h0, rand_word(), 32'hffff_8080, 1'b0);
    // stores of each size plus an undefined funct3
    for (int i = 0; i < 4; i++)
      queue_instr(encode(7'h40, 5'd7, 5'd6, i[2:0], 5'h1f, rvde_pkg::OpcStore), 32'h300,
                  32'h7fff_fff0, rand_word(), rand_word(), 1'b0);
    // SRAI with bit 25 and other junk funct7 bits set
    queue_instr(encode(7'h23, 5'd4, 5'd1, rvde_pkg::F3Sr, 5'd3, rvde_pkg::OpcOpImm), 32'h400,
                32'h8000_0000, rand_word(), rand_word(), 1'b0);
    queue_instr(encode(7'h20, 5'd2, 5'd1, rvde_pkg::F3Add, 5'd7, rvde_pkg::OpcOp), 32'h404,
                32'h0, 32'h1, rand_word(), 1'b0);
    // register shift amount above 31 wraps
    queue_instr(encode(7'h20, 5'd2, 5'd1, rvde_pkg::F3Sr, 5'd8, rvde_pkg::OpcOp), 32'h408,
                32'h8000_0000, 32'd33, rand_word(), 1'b0);
    queue_instr(encode(7'h7f, 5'h1f, 5'd1, rvde_pkg::F3Slt, 5'd9, rvde_pkg::OpcOpImm),
                32'h40c, 32'h8000_0000, rand_word(), rand_word(), 1'b0);
    queue_instr(rvde_pkg::HaltWord, 32'h410, rand_word(), rand_word(), rand_word(), 1'b0);
    queue_instr(32'hffff_ffff, 32'h414, rand_word(), rand_word(), rand_word(), 1'b0);

    for (int i = 0; i < NumRandom; i++) begin
      logic [31:0] ins;
      logic [31:0] a;
      ins = rand_instr();
      a   = rand_word();
      // equal operands give branches something to match on
      queue_instr(ins, rand_word(), a, ($urandom_range(0, 3) == 0) ? a : rand_word(),
                  rand_word(), (i == 0 || i == NumRandom / 2));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample away from the active edge so driver updates have settled
    while (pending_instrs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
